@@ rtl/core/q8_block_dequantizer_macros.svh @@
// ---------------------------------------------------------------------------
// q8 block dequantizer assertion macros
// ---------------------------------------------------------------------------
`ifndef Q8_BLOCK_DEQUANTIZER_MACROS_SVH
`define Q8_BLOCK_DEQUANTIZER_MACROS_SVH
`ifndef SYNTHESIS
`define Q8_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define Q8_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define Q8_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define Q8_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/q8bd_pkg.sv @@
// ---------------------------------------------------------------------------
// q8bd_pkg
// types and constants shared by the q8 block dequantizer
// ---------------------------------------------------------------------------
package q8bd_pkg;
  localparam int LANES = 8;
  localparam logic [9:0] HALF_MANT_MASK = 10'h3FF;
  localparam logic [4:0] HALF_EXP_ALL = 5'h1F;
  localparam logic [7:0] SINGLE_EXP_ALL = 8'hFF;
  localparam logic [31:0] DEFAULT_NAN = 32'hFFC00000;
  localparam logic [31:0] SINGLE_QUIET = 32'h00400000;

  typedef struct packed {
    logic [15:0] scale_half;
    logic signed [7:0] q7, q6, q5, q4, q3, q2, q1, q0;
    logic end_of_row;
  } in_item_t;

  typedef struct packed {
    logic [31:0] y7, y6, y5, y4, y3, y2, y1, y0;
    logic row_done;
  } out_item_t;

  // decoded scale, shared by all lanes
  typedef struct packed {
    logic sign;
    logic is_nan;
    logic is_inf;
    logic [10:0] sig;
    logic [4:0] exp_eff;
    logic [9:0] mant;
  } scale_t;

  // one lane after the multiply
  typedef struct packed {
    logic sign;
    logic q_zero;
    logic [17:0] prod;
  } prod_t;
endpackage

@@ rtl/core/q8_block_dequantizer.sv @@
// ---------------------------------------------------------------------------
// q8_block_dequantizer
// half scale times eight int8 values, exact single precision results
// ---------------------------------------------------------------------------
// channel  dir  payload     handshake
// in_      in   in_item_t   in_valid / in_ready
// out_     out  out_item_t  out_valid / out_ready
//
// three register stages: scale decode, lane multiply, normalize and pack
// one request enters per cycle when out is taken
// every stage advances when the stage ahead is empty or moving
// a stall holds each full stage with no empty stage between it and out; the rest move and fill
// reset clears the valid bits only
`include "q8_block_dequantizer_macros.svh"
module q8_block_dequantizer import q8bd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;
  in_item_t s1_r;
  scale_t sc1_r, sc2_r, sc_nxt;
  logic eor2_r, eor3_r;
  logic [7:0] q1 [LANES];
  prod_t p2 [LANES];
  logic [31:0] y3 [LANES];

  // pipeline advance, stage 3 is the output register
  assign en3 = !v3_r || out_ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;

  // scale decode
  always_comb begin
    sc_nxt.sign = in_data.scale_half[15];
    sc_nxt.mant = in_data.scale_half[9:0] & HALF_MANT_MASK;
    sc_nxt.is_nan = (in_data.scale_half[14:10] == HALF_EXP_ALL) && (sc_nxt.mant != 10'd0);
    sc_nxt.is_inf = (in_data.scale_half[14:10] == HALF_EXP_ALL) && (sc_nxt.mant == 10'd0);
    // subnormal uses exponent one with no hidden bit
    if (in_data.scale_half[14:10] == 5'd0) begin
      sc_nxt.sig = {1'b0, sc_nxt.mant};
      sc_nxt.exp_eff = 5'd1;
    end else begin
      sc_nxt.sig = {1'b1, sc_nxt.mant};
      sc_nxt.exp_eff = in_data.scale_half[14:10];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_r <= in_data;
      sc1_r <= sc_nxt;
    end
    if (en2) begin
      sc2_r <= sc1_r;
      eor2_r <= s1_r.end_of_row;
    end
    if (en3) begin
      eor3_r <= eor2_r;
    end
  end

  assign q1[0] = s1_r.q0;
  assign q1[1] = s1_r.q1;
  assign q1[2] = s1_r.q2;
  assign q1[3] = s1_r.q3;
  assign q1[4] = s1_r.q4;
  assign q1[5] = s1_r.q5;
  assign q1[6] = s1_r.q6;
  assign q1[7] = s1_r.q7;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    q8bd_lane_mul u_mul (.clk(clk), .en(en2), .scale(sc1_r), .q(q1[g]), .prod_r(p2[g]));
    q8bd_lane_norm u_norm (.clk(clk), .en(en3), .scale(sc2_r), .prod(p2[g]), .y_r(y3[g]));
  end

  assign out_valid = v3_r;
  assign out_data = '{y7: y3[7], y6: y3[6], y5: y3[5], y4: y3[4], y3: y3[3],
                      y2: y3[2], y1: y3[1], y0: y3[0], row_done: eor3_r};

  `Q8_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !v1_r, in_ready)
  `Q8_ASSERT_NXT(a_hold_on_stall, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `Q8_ASSERT_NXT(a_take_fills, clk, rst_n, in_valid && in_ready, v1_r)
endmodule

@@ rtl/core/q8bd_lane_mul.sv @@
// ---------------------------------------------------------------------------
// q8bd_lane_mul
// stage 2 lane: scale significand times value magnitude
// ---------------------------------------------------------------------------
module q8bd_lane_mul import q8bd_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  scale_t      scale,
  input  logic [7:0]  q,
  output prod_t       prod_r
);
  logic [7:0] qmag;
  prod_t prod_nxt;

  always_comb begin
    qmag = q[7] ? (8'd0 - q) : q; // -128 gives 8'h80, which is 128
    prod_nxt.sign = scale.sign ^ q[7];
    prod_nxt.q_zero = (q == 8'd0);
    prod_nxt.prod = 18'(scale.sig) * 18'(qmag);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end
endmodule

@@ rtl/core/q8bd_lane_norm.sv @@
// ---------------------------------------------------------------------------
// q8bd_lane_norm
// stage 3 lane: leading one search, shift and pack to single precision
// ---------------------------------------------------------------------------
module q8bd_lane_norm import q8bd_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  scale_t      scale,
  input  prod_t       prod,
  output logic [31:0] y_r
);
  logic [4:0] msb;
  logic [31:0] y_nxt;
  logic [22:0] mant;
  logic [7:0] expf;

  always_comb begin
    msb = 5'd0;
    for (int t = 0; t < 18; t++) begin
      if (prod.prod[t]) msb = 5'(t);
    end
    // exponent: msb + exp_eff - 25 + 127
    expf = 8'(msb) + 8'(scale.exp_eff) + 8'd102;
    mant = 23'({5'd0, prod.prod} << (5'd23 - msb));
    if (scale.is_nan) begin
      y_nxt = {scale.sign, SINGLE_EXP_ALL, scale.mant, 13'd0} | SINGLE_QUIET;
    end else if (scale.is_inf) begin
      y_nxt = prod.q_zero ? DEFAULT_NAN : {prod.sign, SINGLE_EXP_ALL, 23'd0};
    end else if (prod.prod == 18'd0) begin
      y_nxt = {prod.sign, 31'd0};
    end else begin
      y_nxt = {prod.sign, expf, mant};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_r <= y_nxt;
    end
  end
endmodule

@@ tb/q8_block_dequantizer_checker.sv @@
// ---------------------------------------------------------------------------
// q8_block_dequantizer_checker
// watches both channels, predicts each lane product and compares results
// ---------------------------------------------------------------------------
module q8_block_dequantizer_checker import q8bd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending_count,
  output int        results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  out_item_t expected_items[$];

  // exact product of a half scale and a signed byte, as a single bit pattern
  function automatic logic [31:0] dequant_lane(logic [15:0] h, logic [7:0] q);
    logic        hs, qs, sgn;
    logic [4:0]  he;
    logic [9:0]  hm;
    logic [8:0]  qmag;
    logic [10:0] sig;
    logic [17:0] prod;
    int          e0, msb;
    logic [7:0]  expf;
    logic [31:0] shifted;
    hs = h[15];
    he = h[14:10];
    hm = h[9:0];
    qs = q[7];
    qmag = qs ? (9'd256 - {1'b0, q}) : {1'b0, q};
    sgn = hs ^ qs;
    if (he == HALF_EXP_ALL) begin
      if (hm != 0) return {hs, SINGLE_EXP_ALL, hm, 13'd0} | SINGLE_QUIET;
      if (qmag == 0) return DEFAULT_NAN;
      return {sgn, SINGLE_EXP_ALL, 23'd0};
    end
    if (he == 0) begin
      sig = {1'b0, hm};
      e0 = -24;
    end else begin
      sig = {1'b1, hm};
      e0 = int'(he) - 25;
    end
    prod = 18'(sig) * 18'(qmag);
    if (prod == 0) return {sgn, 31'd0};
    msb = 0;
    for (int t = 0; t < 18; t++) if (prod[t]) msb = t;
    expf = 8'(msb + e0 + 127);
    shifted = 32'(prod) << (23 - msb);
    return {sgn, expf, shifted[22:0]};
  endfunction

  function automatic out_item_t dequant_item(in_item_t it);
    out_item_t r;
    r.y0 = dequant_lane(it.scale_half, it.q0);
    r.y1 = dequant_lane(it.scale_half, it.q1);
    r.y2 = dequant_lane(it.scale_half, it.q2);
    r.y3 = dequant_lane(it.scale_half, it.q3);
    r.y4 = dequant_lane(it.scale_half, it.q4);
    r.y5 = dequant_lane(it.scale_half, it.q5);
    r.y6 = dequant_lane(it.scale_half, it.q6);
    r.y7 = dequant_lane(it.scale_half, it.q7);
    r.row_done = it.end_of_row;
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch %s: expected %h actual %h", what, exp_v, act_v);
  endtask

  initial begin
    fail_count = 0;
    results_seen = 0;
  end

  assign pending_count = expected_items.size();

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && in_valid && in_ready) expected_items.push_back(dequant_item(in_data));
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_items.size() == 0) begin
        note_mismatch("unexpected result", 32'd0, out_data.y0);
      end else begin
        e = expected_items.pop_front();
        if (e.y0 != out_data.y0) note_mismatch("y0", e.y0, out_data.y0);
        if (e.y1 != out_data.y1) note_mismatch("y1", e.y1, out_data.y1);
        if (e.y2 != out_data.y2) note_mismatch("y2", e.y2, out_data.y2);
        if (e.y3 != out_data.y3) note_mismatch("y3", e.y3, out_data.y3);
        if (e.y4 != out_data.y4) note_mismatch("y4", e.y4, out_data.y4);
        if (e.y5 != out_data.y5) note_mismatch("y5", e.y5, out_data.y5);
        if (e.y6 != out_data.y6) note_mismatch("y6", e.y6, out_data.y6);
        if (e.y7 != out_data.y7) note_mismatch("y7", e.y7, out_data.y7);
        if (e.row_done != out_data.row_done)
          note_mismatch("row_done", 32'(e.row_done), 32'(out_data.row_done));
      end
    end
  end
endmodule

@@ tb/q8_block_dequantizer_tb.sv @@
// ---------------------------------------------------------------------------
// q8_block_dequantizer_tb
// drives scale and byte requests with random gaps and back pressure
// ---------------------------------------------------------------------------
module q8_block_dequantizer_tb import q8bd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQUESTS = 1500;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        fail_count, pending_count, results_seen;
  int        idle_cycles = 0;
  int        requests_sent = 0;
  bit        no_idle = 1'b0;   // set during the gap-free stretch

  always #5 clk = ~clk;

  q8_block_dequantizer uut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data
  );

  q8_block_dequantizer_checker chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .fail_count, .pending_count, .results_seen
  );

  // receiver stalls with a chance of about 16 percent, none in the quiet stretch
  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 16);
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // one request: hold valid until accepted, maybe idle first
  task automatic send_request(in_item_t it);
    if (!no_idle) begin
      while ($urandom_range(99) < 16) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h80;
      1: return 8'h7F;
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_scale();
    logic [15:0] h;
    h = 16'($urandom);
    case ($urandom_range(9))
      0: h[14:10] = 5'h00;           // zero or subnormal
      1: h[14:10] = HALF_EXP_ALL;    // infinity or nan
      2: h[9:0] = 10'd0;
      default: ;
    endcase
    return h;
  endfunction

  function automatic in_item_t build_request(logic [15:0] h, logic [7:0] b, logic eor);
    in_item_t it;
    it.scale_half = h;
    it.q0 = b; it.q1 = 8'h80; it.q2 = 8'h7F; it.q3 = 8'h00;
    it.q4 = 8'hFF; it.q5 = 8'h01; it.q6 = ~b; it.q7 = 8'($urandom);
    it.end_of_row = eor;
    return it;
  endfunction

  function automatic in_item_t random_request();
    in_item_t it;
    it.scale_half = pick_scale();
    it.q0 = pick_byte(); it.q1 = pick_byte(); it.q2 = pick_byte(); it.q3 = pick_byte();
    it.q4 = pick_byte(); it.q5 = pick_byte(); it.q6 = pick_byte(); it.q7 = pick_byte();
    it.end_of_row = 1'($urandom);
    return it;
  endfunction

  initial begin
    logic [15:0] directed_scales[16];
    int waited;
    directed_scales = '{16'h0000, 16'h8000, 16'h0001, 16'h83FF, 16'h0400, 16'h3C00,
                        16'hBC00, 16'h7BFF, 16'hFBFF, 16'h7C00, 16'hFC00, 16'h7C01,
                        16'hFE00, 16'h7FFF, 16'h03FF, 16'h5555};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: scale extremes, zero, subnormal, inf, nan against byte extremes
    foreach (directed_scales[i])
      send_request(build_request(directed_scales[i], 8'(i * 17), 1'(i)));
    send_request(build_request(16'hAAAA, 8'h55, 1'b0));

    // random requests with a long gap-free stretch in the middle
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      no_idle = (n >= 600 && n < 900);
      send_request(random_request());
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    waited = 0;
    while (pending_count != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d requests, checked %0d results across zero, subnormal,",
             requests_sent, results_seen);
    $display("normal, infinite and nan scales, with random gaps and stalls");
    if (fail_count == 0 && pending_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
